// ===== src/fnpll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N PLL word calculator package
// Shared widths, constants, codes and the divider request and response types.
// ----------------------------------------------------------------------------
package fnpll_pkg;

  localparam int FREQ_W  = 33;
  localparam int CFG_W   = 30;
  localparam int CFG_A_W = 3;
  localparam int DIV_W   = 56;
  localparam int DIV_C_W = $clog2(DIV_W);

  localparam logic [CFG_A_W-1:0] REG_REF_FREQ  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_REF_DIV   = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_REF_HALVE = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_REF_DBL   = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_STEP      = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_CP_CODE   = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_MAIN_PWR = 4'd1;
  localparam logic [3:0] ST_AUX_PWR  = 4'd2;
  localparam logic [3:0] ST_ZERO_PFD = 4'd3;
  localparam logic [3:0] ST_R_OVF    = 4'd4;
  localparam logic [3:0] ST_FREQ     = 4'd5;
  localparam logic [3:0] ST_N_RANGE  = 4'd6;
  localparam logic [3:0] ST_MOD2     = 4'd7;
  localparam logic [3:0] ST_FRAC2    = 4'd8;

  localparam logic [32:0] FREQ_MAX_HZ    = 33'd6800000000;
  localparam logic [32:0] FREQ_MIN_HZ    = 33'd53125000;
  localparam logic [31:0] LO_RATIO_BASE  = 32'd3400000000;
  localparam int          FRAC1_SHIFT    = 24;
  localparam logic [26:0] BLEED_SCALE    = 27'd125000000;
  localparam logic [11:0] BLEED_DIV      = 12'd3750;
  localparam logic [6:0]  ROUND_HALF     = 7'd50;
  localparam logic [6:0]  ROUND_DIV      = 7'd100;
  localparam logic [7:0]  BLEED_SAT      = 8'd255;
  localparam logic [13:0] MOD2_MAX       = 14'd16383;
  localparam logic [14:0] N_MAX          = 15'd32767;
  localparam logic [4:0]  N_MIN          = 5'd23;
  localparam logic [9:0]  R_BIG          = 10'd511;
  localparam logic [26:0] PFD_R_LIMIT_HZ = 27'd75000000;
  localparam logic [26:0] PFD_BLEED_HZ   = 27'd100000000;
  localparam logic [2:0]  SEL_AT_MIN     = 3'd6;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/fnpll_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one frequency request item with its two output power levels.
// ----------------------------------------------------------------------------
interface fnpll_in_if;
  logic        valid;
  logic        ready;
  logic [32:0] freq_hz;
  logic [2:0]  main_power;
  logic [2:0]  aux_power;

  modport source (output valid, freq_hz, main_power, aux_power, input ready);
  modport sink   (input valid, freq_hz, main_power, aux_power, output ready);
endinterface

// ===== src/fnpll_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one item of synthesizer words and status.
// ----------------------------------------------------------------------------
interface fnpll_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] int_value;
  logic [23:0] frac1;
  logic [13:0] frac2;
  logic [13:0] mod2;
  logic [2:0]  out_div_select;
  logic        main_enable;
  logic [1:0]  main_level;
  logic        aux_enable;
  logic [1:0]  aux_level;
  logic        negative_bleed;
  logic [7:0]  bleed_current;

  modport source (output valid, status, int_value, frac1, frac2, mod2, out_div_select,
                  main_enable, main_level, aux_enable, aux_level, negative_bleed,
                  bleed_current, input ready);
  modport sink   (input valid, status, int_value, frac1, frac2, mod2, out_div_select,
                  main_enable, main_level, aux_enable, aux_level, negative_bleed,
                  bleed_current, output ready);
endinterface

// ===== src/fnpll_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; quotient and remainder on a done pulse.
// ----------------------------------------------------------------------------
module fnpll_div (
  input  logic                clk,
  input  logic                rst_n,
  input  fnpll_pkg::div_req_t req,
  output fnpll_pkg::div_rsp_t rsp
);

  localparam int W = fnpll_pkg::DIV_W;

  logic                         busy_r;
  logic                         done_r;
  logic [fnpll_pkg::DIV_C_W-1:0] cnt_r;
  logic [W-1:0]                 rem_r;
  logic [W-1:0]                 quo_r;
  logic [W-1:0]                 dvs_r;
  logic [W:0]                   trial;
  logic                         fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= fnpll_pkg::DIV_C_W'(W - 1);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
        quo_r <= {quo_r[W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/fractional_n_pll_word_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N PLL word calculator
// Turns a requested output frequency into divider, INT, FRAC1, MOD2, FRAC2,
// bleed and output power words, using exact integer arithmetic.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Carries
//   in_if     sink       valid / ready      freq_hz, main_power, aux_power
//   out_if    source     valid / ready      status and synthesizer words
//   cfg_*     sink       cfg_we only        register index and write data
//
// Every quotient and remainder comes from a single shared restoring divider
// at one bit per cycle; the gcd loop needs one division per Euclid step.
// Error items finish early, after the check that fails.
// Reset is synchronous and active low; it restores the register defaults.
// A finished item waits in the output register while the next one is taken;
// a stalled output holds the sequencer only at its final step.
//
module fractional_n_pll_word_calculator (
  input  logic                            clk,
  input  logic                            rst_n,
  fnpll_in_if.sink                        in_if,
  fnpll_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [fnpll_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [fnpll_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int W = fnpll_pkg::DIV_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RATIO = 4'd2;
  localparam logic [3:0] S_N     = 4'd3;
  localparam logic [3:0] S_F1    = 4'd4;
  localparam logic [3:0] S_A     = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_G     = 4'd7;
  localparam logic [3:0] S_M2    = 4'd8;
  localparam logic [3:0] S_F2L   = 4'd9;
  localparam logic [3:0] S_F2    = 4'd10;
  localparam logic [3:0] S_B1    = 4'd11;
  localparam logic [3:0] S_B2    = 4'd12;
  localparam logic [3:0] S_B3    = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;
  localparam logic [3:0] S_MUL   = 4'd15;

  // Configuration registers
  logic [29:0] ref_freq_r;
  logic [9:0]  ref_div_r;
  logic        ref_halve_r;
  logic        ref_dbl_r;
  logic [26:0] step_r;
  logic [3:0]  cp_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r  <= 30'd122880000;
      ref_div_r   <= 10'd1;
      ref_halve_r <= 1'b0;
      ref_dbl_r   <= 1'b0;
      step_r      <= 27'd25000;
      cp_code_r   <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fnpll_pkg::REG_REF_FREQ:  ref_freq_r  <= cfg_wdata[29:0];
        fnpll_pkg::REG_REF_DIV:   ref_div_r   <= cfg_wdata[9:0];
        fnpll_pkg::REG_REF_HALVE: ref_halve_r <= cfg_wdata[0];
        fnpll_pkg::REG_REF_DBL:   ref_dbl_r   <= cfg_wdata[0];
        fnpll_pkg::REG_STEP:      step_r      <= cfg_wdata[26:0];
        fnpll_pkg::REG_CP_CODE:   cp_code_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [3:0]  state_r;
  logic [32:0] freq_r;
  logic [2:0]  mp_r, ap_r;
  logic [30:0] p_r;          // PFD numerator
  logic [10:0] q_r;          // PFD denominator
  logic [2:0]  sel_r;
  logic [50:0] n_r;
  logic [23:0] frac1_r;
  logic [30:0] rem2_r;
  logic [30:0] gy_r;
  logic [30:0] g_r;
  logic [13:0] mod2_r;
  logic [13:0] frac2_r;
  logic [44:0] prod_r;
  logic [7:0]  bleed_r;
  logic [3:0]  status_r;

  logic          div_go_r;
  logic [W-1:0]  div_a_r, div_b_r;
  fnpll_pkg::div_req_t div_req;
  fnpll_pkg::div_rsp_t div_rsp;

  assign div_req.go       = div_go_r;
  assign div_req.dividend = div_a_r;
  assign div_req.divisor  = div_b_r;

  fnpll_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register
  logic        out_valid_r;
  logic [3:0]  o_status_r;
  logic [15:0] o_int_r;
  logic [23:0] o_frac1_r;
  logic [13:0] o_frac2_r;
  logic [13:0] o_mod2_r;
  logic [2:0]  o_sel_r;
  logic        o_men_r, o_aen_r, o_nbleed_r;
  logic [1:0]  o_mlev_r, o_alev_r;
  logic [7:0]  o_bleed_r;

  logic accept;
  logic load_out;
  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign load_out    = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  // Early checks, the output divider choice and small products
  logic [37:0] r_limit;
  logic [37:0] bleed_limit;
  logic [7:0]  ratio;
  logic [2:0]  sel_cnt;
  logic [39:0] freq_sh;
  logic [50:0] num;
  logic [31:0] bleed_num;
  logic        ok_path;

  assign r_limit     = 38'(fnpll_pkg::PFD_R_LIMIT_HZ) * 38'(q_r);
  assign bleed_limit = 38'(fnpll_pkg::PFD_BLEED_HZ) * 38'(q_r);
  assign ratio       = div_rsp.quo[7:0];
  assign freq_sh     = 40'(freq_r) << sel_r;
  assign num         = 51'(freq_sh) * 51'(q_r);
  assign bleed_num   = 32'(fnpll_pkg::BLEED_SCALE) * 32'({1'b0, cp_code_r} + 5'd1);
  assign ok_path     = (status_r == fnpll_pkg::ST_OK);

  // The divider doubles from one while it does not exceed the ratio, at most to 128.
  always_comb begin
    sel_cnt = '0;
    for (int k = 0; k < 7; k++) begin
      if ((8'd1 << k) <= ratio) sel_cnt = sel_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            freq_r   <= in_if.freq_hz;
            mp_r     <= in_if.main_power;
            ap_r     <= in_if.aux_power;
            p_r      <= ref_dbl_r ? {ref_freq_r, 1'b0} : {1'b0, ref_freq_r};
            q_r      <= ref_halve_r ? {ref_div_r, 1'b0} : {1'b0, ref_div_r};
            status_r <= fnpll_pkg::ST_OK;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (mp_r > 3'd4) begin
            status_r <= fnpll_pkg::ST_MAIN_PWR;
            state_r  <= S_FIN;
          end else if (ap_r > 3'd4) begin
            status_r <= fnpll_pkg::ST_AUX_PWR;
            state_r  <= S_FIN;
          end else if (ref_freq_r == '0 || ref_div_r == '0) begin
            status_r <= fnpll_pkg::ST_ZERO_PFD;
            state_r  <= S_FIN;
          end else if (38'(p_r) > r_limit && ref_div_r > fnpll_pkg::R_BIG) begin
            status_r <= fnpll_pkg::ST_R_OVF;
            state_r  <= S_FIN;
          end else if (freq_r > fnpll_pkg::FREQ_MAX_HZ || freq_r < fnpll_pkg::FREQ_MIN_HZ) begin
            status_r <= fnpll_pkg::ST_FREQ;
            state_r  <= S_FIN;
          end else if (freq_r == fnpll_pkg::FREQ_MIN_HZ) begin
            sel_r   <= fnpll_pkg::SEL_AT_MIN;
            state_r <= S_MUL;
          end else begin
            div_a_r  <= W'(fnpll_pkg::LO_RATIO_BASE);
            div_b_r  <= W'(freq_r);
            div_go_r <= 1'b1;
            state_r  <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (div_rsp.done) begin
            sel_r   <= sel_cnt;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          div_a_r  <= W'(num);
          div_b_r  <= W'(p_r);
          div_go_r <= 1'b1;
          state_r  <= S_N;
        end
        S_N: begin
          if (div_rsp.done) begin
            n_r      <= div_rsp.quo[50:0];
            div_a_r  <= W'(div_rsp.rem[30:0]) << fnpll_pkg::FRAC1_SHIFT;
            div_b_r  <= W'(p_r);
            div_go_r <= 1'b1;
            state_r  <= S_F1;
          end
        end
        S_F1: begin
          if (div_rsp.done) begin
            frac1_r  <= div_rsp.quo[23:0];
            rem2_r   <= div_rsp.rem[30:0];
            div_a_r  <= W'(p_r);
            div_b_r  <= W'(q_r);
            div_go_r <= 1'b1;
            state_r  <= S_A;
          end
        end
        S_A: begin
          // Integer part of the PFD against the channel step; zero operands
          // give the other operand.
          if (div_rsp.done) begin
            priority if (step_r == '0) begin
              g_r     <= div_rsp.quo[30:0];
              state_r <= S_G;
            end else if (div_rsp.quo == '0) begin
              g_r     <= 31'(step_r);
              state_r <= S_G;
            end else begin
              gy_r     <= 31'(step_r);
              div_a_r  <= div_rsp.quo;
              div_b_r  <= W'(step_r);
              div_go_r <= 1'b1;
              state_r  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              g_r     <= gy_r;
              state_r <= S_G;
            end else begin
              gy_r     <= div_rsp.rem[30:0];
              div_a_r  <= W'(gy_r);
              div_b_r  <= div_rsp.rem;
              div_go_r <= 1'b1;
            end
          end
        end
        S_G: begin
          priority if (n_r < 51'(fnpll_pkg::N_MIN) || n_r > 51'(fnpll_pkg::N_MAX)) begin
            status_r <= fnpll_pkg::ST_N_RANGE;
            state_r  <= S_FIN;
          end else if (g_r == '0) begin
            status_r <= fnpll_pkg::ST_MOD2;
            state_r  <= S_FIN;
          end else begin
            div_a_r  <= W'(p_r);
            div_b_r  <= W'(42'(q_r) * 42'(g_r));
            div_go_r <= 1'b1;
            state_r  <= S_M2;
          end
        end
        S_M2: begin
          if (div_rsp.done) begin
            if (div_rsp.quo < W'(2) || div_rsp.quo > W'(fnpll_pkg::MOD2_MAX)) begin
              status_r <= fnpll_pkg::ST_MOD2;
              state_r  <= S_FIN;
            end else begin
              mod2_r  <= div_rsp.quo[13:0];
              prod_r  <= 45'(rem2_r) * 45'(div_rsp.quo[13:0]);
              state_r <= S_F2L;
            end
          end
        end
        S_F2L: begin
          // Rounded FRAC2: (2*rem2*mod2 + p) / (2*p)
          div_a_r  <= W'({prod_r, 1'b0}) + W'(p_r);
          div_b_r  <= W'({p_r, 1'b0});
          div_go_r <= 1'b1;
          state_r  <= S_F2;
        end
        S_F2: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > W'(mod2_r)) begin
              status_r <= fnpll_pkg::ST_FRAC2;
              state_r  <= S_FIN;
            end else begin
              frac2_r  <= div_rsp.quo[13:0];
              div_a_r  <= W'(bleed_num);
              div_b_r  <= W'(n_r);
              div_go_r <= 1'b1;
              state_r  <= S_B1;
            end
          end
        end
        S_B1: begin
          if (div_rsp.done) begin
            div_a_r  <= div_rsp.quo;
            div_b_r  <= W'(fnpll_pkg::BLEED_DIV);
            div_go_r <= 1'b1;
            state_r  <= S_B2;
          end
        end
        S_B2: begin
          if (div_rsp.done) begin
            div_a_r  <= div_rsp.quo + W'(fnpll_pkg::ROUND_HALF);
            div_b_r  <= W'(fnpll_pkg::ROUND_DIV);
            div_go_r <= 1'b1;
            state_r  <= S_B3;
          end
        end
        S_B3: begin
          if (div_rsp.done) begin
            bleed_r <= (div_rsp.quo > W'(fnpll_pkg::BLEED_SAT)) ? fnpll_pkg::BLEED_SAT
                                                                : div_rsp.quo[7:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register; an error item carries only its status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r <= status_r;
      o_int_r    <= ok_path ? n_r[15:0] : '0;
      o_frac1_r  <= ok_path ? frac1_r : '0;
      o_frac2_r  <= ok_path ? frac2_r : '0;
      o_mod2_r   <= ok_path ? mod2_r : '0;
      o_sel_r    <= ok_path ? sel_r : '0;
      o_men_r    <= ok_path && (mp_r != '0);
      o_mlev_r   <= (ok_path && mp_r != '0) ? 2'(mp_r - 3'd1) : '0;
      o_aen_r    <= ok_path && (ap_r != '0);
      o_alev_r   <= (ok_path && ap_r != '0) ? 2'(ap_r - 3'd1) : '0;
      o_nbleed_r <= ok_path && (frac1_r != '0 || frac2_r != '0) && (38'(p_r) <= bleed_limit);
      o_bleed_r  <= ok_path ? bleed_r : '0;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = o_status_r;
  assign out_if.int_value      = o_int_r;
  assign out_if.frac1          = o_frac1_r;
  assign out_if.frac2          = o_frac2_r;
  assign out_if.mod2           = o_mod2_r;
  assign out_if.out_div_select = o_sel_r;
  assign out_if.main_enable    = o_men_r;
  assign out_if.main_level     = o_mlev_r;
  assign out_if.aux_enable     = o_aen_r;
  assign out_if.aux_level      = o_alev_r;
  assign out_if.negative_bleed = o_nbleed_r;
  assign out_if.bleed_current  = o_bleed_r;

endmodule

// ===== test/tb_fractional_n_pll_word_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N PLL word calculator testbench
// Drives frequency request items through a series of reference settings,
// predicts every set of synthesizer words in exact integer arithmetic and
// compares each result item field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_fractional_n_pll_word_calculator;
  import fnpll_pkg::*;

  // The run limit leaves a wide margin over roughly 640 slow items, each with
  // its worst gap and stall on top.
  localparam int unsigned RUN_LIMIT = 8000000;
  localparam int unsigned DRAIN_CYCLES = 3200;

  typedef struct packed {
    logic [32:0] freq;
    logic [2:0]  main_pwr;
    logic [2:0]  aux_pwr;
  } request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] int_value;
    logic [23:0] frac1;
    logic [13:0] frac2;
    logic [13:0] mod2;
    logic [2:0]  div_sel;
    logic        main_en;
    logic [1:0]  main_lvl;
    logic        aux_en;
    logic [1:0]  aux_lvl;
    logic        neg_bleed;
    logic [7:0]  bleed;
  } words_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  fnpll_in_if  req_ch ();
  fnpll_out_if word_ch ();

  fractional_n_pll_word_calculator uut (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch.sink), .out_if(word_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // The testbench's own copy of the register file, kept in step with writes.
  logic [29:0] ref_hz;
  logic [9:0]  r_count;
  logic        halve;
  logic        dbl;
  logic [26:0] step_hz;
  logic [3:0]  cp_code;

  request_t req_q[$];   // requests waiting to be offered
  words_t   words_q[$]; // predicted words, oldest first

  int unsigned cycle_cnt;
  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned n_got;
  int unsigned status_seen[16];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Works out the synthesizer words for one request under the current
  // register settings. The PFD is kept as the exact fraction p / q.
  function automatic words_t calc_words(request_t rq);
    words_t w;
    bit [63:0] p, q, num, n, rem, f1x, fr1, rem2, a, b, t, g, m2, fr2;
    bit [63:0] ratio, odiv, sel, bl;
    w = '0;
    if (rq.main_pwr > 4) begin
      w.status = ST_MAIN_PWR;
      return w;
    end
    if (rq.aux_pwr > 4) begin
      w.status = ST_AUX_PWR;
      return w;
    end
    if (ref_hz == 0 || r_count == 0) begin
      w.status = ST_ZERO_PFD;
      return w;
    end
    p = 64'(ref_hz) * (1 + 64'(dbl));
    q = 64'(r_count) * (1 + 64'(halve));
    if (p > 64'd75000000 * q && r_count > 511) begin
      w.status = ST_R_OVF;
      return w;
    end
    if (rq.freq > 64'd6800000000 || rq.freq < 64'd53125000) begin
      w.status = ST_FREQ;
      return w;
    end
    odiv = 1;
    sel = 0;
    if (rq.freq == 64'd53125000) begin
      odiv = 64;
      sel = 6;
    end else begin
      ratio = (64'd3400000000 / 64'(rq.freq)) & 64'hFF;
      while (odiv <= ratio && odiv <= 64) begin
        odiv = odiv * 2;
        sel = sel + 1;
      end
    end
    num = 64'(rq.freq) * odiv * q;
    n = num / p;
    rem = num % p;
    f1x = rem << 24;
    fr1 = f1x / p;
    rem2 = f1x % p;
    // MOD2 comes from the gcd of the whole PFD and the channel step.
    a = p / q;
    if (step_hz == 0) begin
      g = a;
    end else if (a == 0) begin
      g = 64'(step_hz);
    end else begin
      b = 64'(step_hz);
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      g = a;
    end
    m2 = (g == 0) ? 64'd0 : p / (q * g);
    if (n < 23 || n > 32767) begin
      w.status = ST_N_RANGE;
      return w;
    end
    if (m2 < 2 || m2 > 16383) begin
      w.status = ST_MOD2;
      return w;
    end
    fr2 = (2 * rem2 * m2 + p) / (2 * p);
    if (fr2 > m2) begin
      w.status = ST_FRAC2;
      return w;
    end
    bl = (64'(cp_code) + 1) * 64'd125000000;
    bl = bl / n;
    bl = bl / 3750;
    bl = (bl + 50) / 100;
    if (bl > 255) bl = 255;
    w.status    = ST_OK;
    w.int_value = n[15:0];
    w.frac1     = fr1[23:0];
    w.frac2     = fr2[13:0];
    w.mod2      = m2[13:0];
    w.div_sel   = sel[2:0];
    w.main_en   = (rq.main_pwr != 0);
    w.main_lvl  = (rq.main_pwr != 0) ? 2'(rq.main_pwr - 1) : 2'd0;
    w.aux_en    = (rq.aux_pwr != 0);
    w.aux_lvl   = (rq.aux_pwr != 0) ? 2'(rq.aux_pwr - 1) : 2'd0;
    w.neg_bleed = ((fr1 != 0 || fr2 != 0) && p <= 64'd100000000 * q);
    w.bleed     = bl[7:0];
    return w;
  endfunction

  // Gaps of zero are drawn often, so long runs without idling occur as well.
  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Sender: offers queued requests, pausing a random number of cycles
  // before each one. The prediction is made at the edge of acceptance.
  int unsigned send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap <= draw_gap();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        words_q.push_back(calc_words({req_ch.freq_hz, req_ch.main_power,
                                      req_ch.aux_power}));
        n_sent++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        req_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        request_t rq;
        rq = req_q.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.freq_hz    <= rq.freq;
        req_ch.main_power <= rq.main_pwr;
        req_ch.aux_power  <= rq.aux_pwr;
        send_gap <= draw_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Receiver: stalls a random number of cycles before each result item and
  // checks every accepted item against the oldest prediction.
  int unsigned stall_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      word_ch.ready <= 1'b0;
      stall_cnt <= draw_gap();
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        if (words_q.size() == 0) begin
          $display("%0t: unexpected result item, status %0d", $realtime,
                   word_ch.status);
          n_fail++;
        end else begin
          words_t e;
          e = words_q.pop_front();
          n_got++;
          status_seen[e.status]++;
          check_field("status", e.status, word_ch.status);
          check_field("int_value", e.int_value, word_ch.int_value);
          check_field("frac1", e.frac1, word_ch.frac1);
          check_field("frac2", e.frac2, word_ch.frac2);
          check_field("mod2", e.mod2, word_ch.mod2);
          check_field("out_div_select", e.div_sel, word_ch.out_div_select);
          check_field("main_enable", e.main_en, word_ch.main_enable);
          check_field("main_level", e.main_lvl, word_ch.main_level);
          check_field("aux_enable", e.aux_en, word_ch.aux_enable);
          check_field("aux_level", e.aux_lvl, word_ch.aux_level);
          check_field("negative_bleed", e.neg_bleed, word_ch.negative_bleed);
          check_field("bleed_current", e.bleed, word_ch.bleed_current);
        end
        stall_cnt <= draw_gap();
        word_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        word_ch.ready <= 1'b0;
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, words_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_REF_FREQ:  ref_hz  = data[29:0];
      REG_REF_DIV:   r_count = data[9:0];
      REG_REF_HALVE: halve   = data[0];
      REG_REF_DBL:   dbl     = data[0];
      REG_STEP:      step_hz = data[26:0];
      REG_CP_CODE:   cp_code = data[3:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [29:0] f, logic [9:0] r, logic h, logic d,
                               logic [26:0] s, logic [3:0] c);
    write_reg(REG_REF_FREQ, 30'(f));
    write_reg(REG_REF_DIV, 30'(r));
    write_reg(REG_REF_HALVE, 30'(h));
    write_reg(REG_REF_DBL, 30'(d));
    write_reg(REG_STEP, 30'(s));
    write_reg(REG_CP_CODE, 30'(c));
    cfg_we <= 1'b0;
  endtask

  // Holds off until every queued request has gone and every result is in.
  // Every request yields a result, so an empty prediction queue means idle.
  task automatic wait_idle();
    while (req_q.size() != 0 || req_ch.valid || words_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [2:0] draw_power();
    return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
  endfunction

  // Mostly frequencies inside the legal band, with a little noise over the
  // whole 33-bit field and the occasional exact lower limit.
  task automatic queue_random(int unsigned count);
    request_t rq;
    repeat (count) begin
      case ($urandom_range(0, 19))
        0: rq.freq = 33'({$urandom, $urandom});
        1: rq.freq = 33'd53125000;
        default: rq.freq = 33'(64'd53125000 + ({$urandom, $urandom} % 64'd6746875001));
      endcase
      rq.main_pwr = draw_power();
      rq.aux_pwr  = draw_power();
      req_q.push_back(rq);
    end
  endtask

  task automatic queue_req(logic [32:0] f, logic [2:0] mp, logic [2:0] ap);
    req_q.push_back({f, mp, ap});
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_REF_FREQ;
    cfg_wdata = '0;
    req_ch.valid      = 1'b0;
    req_ch.freq_hz    = '0;
    req_ch.main_power = '0;
    req_ch.aux_power  = '0;
    word_ch.ready     = 1'b0;
    cycle_cnt = 0;
    n_fail = 0;
    n_sent = 0;
    n_got  = 0;
    // Register values after reset.
    ref_hz  = 30'd122880000;
    r_count = 10'd1;
    halve   = 1'b0;
    dbl     = 1'b0;
    step_hz = 27'd25000;
    cp_code = 4'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: MOD2 comes out too large, so most items end in a
    // MOD2 range error.
    queue_random(40);
    wait_idle();

    // A 100 MHz reference with the largest charge pump code. The directed
    // items cover the band edges, the exact 53.125 MHz divider choice, the
    // full field extremes and every power code on both outputs.
    load_settings(30'd100000000, 10'd1, 1'b0, 1'b0, 27'd25000, 4'd15);
    queue_req(33'd53125000, 3'd1, 3'd0);
    queue_req(33'd53124999, 3'd2, 3'd1);
    queue_req(33'd53125001, 3'd3, 3'd2);
    queue_req(33'd6800000000, 3'd4, 3'd3);
    queue_req(33'd6800000001, 3'd0, 3'd4);
    queue_req(33'd0, 3'd1, 3'd1);
    queue_req({33{1'b1}}, 3'd1, 3'd1);
    queue_req(33'd3400000000, 3'd0, 3'd0);
    queue_req(33'd3399999999, 3'd4, 3'd4);
    queue_req(33'd1700000000, 3'd2, 3'd3);
    queue_req(33'd106250000, 3'd3, 3'd2);
    queue_req(33'd4000000000, 3'd5, 3'd1);
    queue_req(33'd4000000000, 3'd7, 3'd7);
    queue_req(33'd4000000000, 3'd6, 3'd0);
    queue_req(33'd4000000000, 3'd1, 3'd5);
    queue_req(33'd4000000000, 3'd0, 3'd6);
    queue_req(33'd4000000000, 3'd0, 3'd7);
    queue_req(33'd4000012345, 3'd2, 3'd2);
    queue_req(33'd5555555555, 3'd3, 3'd1);
    queue_req(33'd4294967296, 3'd4, 3'd0);
    queue_random(120);
    wait_idle();

    // Halved reference: a non-integer PFD ratio with a legal MOD2.
    load_settings(30'd122880000, 10'd1, 1'b1, 1'b0, 27'd25000, 4'd7);
    queue_random(120);
    wait_idle();

    // Doubled low reference and the smallest charge pump code.
    load_settings(30'd10000000, 10'd1, 1'b0, 1'b1, 27'd5000, 4'd0);
    queue_random(100);
    wait_idle();

    // Largest reference, largest R counter, both halve and double, widest
    // step: MOD2 comes out too large.
    load_settings(30'd600000000, 10'd1023, 1'b1, 1'b1, 27'd125000000, 4'd15);
    queue_random(40);
    wait_idle();

    // Zero reference, then zero R counter: both give a zero PFD.
    load_settings(30'd0, 10'd1, 1'b0, 1'b0, 27'd25000, 4'd3);
    queue_random(20);
    wait_idle();
    load_settings(30'd100000000, 10'd0, 1'b0, 1'b0, 27'd25000, 4'd3);
    queue_random(20);
    wait_idle();

    // Zero channel step: the gcd falls back to the whole PFD.
    load_settings(30'd100000000, 10'd1, 1'b0, 1'b0, 27'd0, 4'd9);
    queue_random(30);
    wait_idle();

    // A step that divides the PFD exactly, giving a large legal MOD2.
    load_settings(30'd61440000, 10'd1, 1'b0, 1'b0, 27'd7680, 4'd5);
    queue_random(100);
    wait_idle();

    // A very high PFD, so N mostly falls below its lower limit.
    load_settings(30'd600000000, 10'd1, 1'b0, 1'b1, 27'd125000000, 4'd15);
    queue_random(30);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d request items over ten register settings.",
             n_got, n_sent);
    $display("Statuses: ok %0d, power %0d, zero PFD %0d, range %0d, MOD2 %0d, FRAC2 %0d.",
             status_seen[ST_OK], status_seen[ST_MAIN_PWR] + status_seen[ST_AUX_PWR],
             status_seen[ST_ZERO_PFD],
             status_seen[ST_FREQ] + status_seen[ST_N_RANGE],
             status_seen[ST_MOD2], status_seen[ST_FRAC2]);
    if (n_fail == 0 && words_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
